// ===== rtl/core/kfrc_pkg.sv =====
// Package for the keypad frequency ramp controller.
// Holds the mode, key, status, LED and register index codes shared by the core files.
// No dependencies.
`default_nettype none

package kfrc_pkg;

  // Default frequency width and reset setpoint.
  localparam int FREQ_BITS_DEF  = 8;
  localparam int SETPOINT_RESET = 60;

  // Input stream field widths and the padded tdata width.
  localparam int KEY_BITS    = 3;
  localparam int STATUS_BITS = 2;
  localparam int IN_FIELDS_W = 3 * KEY_BITS + STATUS_BITS + 1;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Configuration register width and defaults.
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_DATA_W-1:0] FREQ_CEIL_RESET  = 8'd90;
  localparam logic [CFG_DATA_W-1:0] FREQ_FLOOR_RESET = 8'd1;

  // Configuration register indexes.
  typedef enum logic {
    CFG_FREQ_CEIL  = 1'b0,
    CFG_FREQ_FLOOR = 1'b1
  } cfg_index_t;

  // Controller modes.
  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_CONFIG = 2'd1,
    MODE_UPDATE = 2'd2
  } mode_t;

  // Key codes.
  localparam logic [KEY_BITS-1:0] KEY_NONE   = 3'd0;
  localparam logic [KEY_BITS-1:0] KEY_ONE    = 3'd1;
  localparam logic [KEY_BITS-1:0] KEY_TWO    = 3'd2;
  localparam logic [KEY_BITS-1:0] KEY_MENU   = 3'd3;
  localparam logic [KEY_BITS-1:0] KEY_SMOOTH = 3'd4;

  // Motor status codes.
  localparam logic [STATUS_BITS-1:0] ST_INITIAL  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_STARTED  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_STOPPED  = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_UPDATING = 2'd3;

  // Status LED codes.
  typedef enum logic [1:0] {
    LED_NONE  = 2'd0,
    LED_RED   = 2'd1,
    LED_GREEN = 2'd2,
    LED_BLUE  = 2'd3
  } led_t;

  // Per-transfer command and flag group produced by the step logic.
  typedef struct packed {
    logic changed;
    logic start;
    logic stop;
    led_t led;
  } step_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/kfrc_step.sv =====
// Next-state and result logic of the keypad frequency ramp controller.
// Purely combinational; depends on kfrc_pkg.
`default_nettype none

module kfrc_step #(
  parameter int FREQ_BITS = kfrc_pkg::FREQ_BITS_DEF
) (
  input  kfrc_pkg::mode_t                         mode,
  input  logic [FREQ_BITS-1:0]                    setpoint,
  input  logic [FREQ_BITS-1:0]                    actual,
  input  logic                                    smooth,
  input  logic [kfrc_pkg::STATUS_BITS-1:0]        status,
  input  logic [kfrc_pkg::CFG_DATA_W-1:0]         freq_ceil,
  input  logic [kfrc_pkg::CFG_DATA_W-1:0]         freq_floor,
  input  logic [kfrc_pkg::KEY_BITS-1:0]           key_press,
  input  logic [kfrc_pkg::KEY_BITS-1:0]           key_repeat,
  input  logic [kfrc_pkg::KEY_BITS-1:0]           key_raw,
  input  logic [kfrc_pkg::STATUS_BITS-1:0]        status_in,
  input  logic                                    ramp_tick,
  output kfrc_pkg::mode_t                         mode_nxt,
  output logic [FREQ_BITS-1:0]                    setpoint_nxt,
  output logic [FREQ_BITS-1:0]                    actual_nxt,
  output logic                                    smooth_nxt,
  output logic [kfrc_pkg::STATUS_BITS-1:0]        status_nxt,
  output kfrc_pkg::step_flags_t                   flags
);
  import kfrc_pkg::*;

  // Compare width covers both the bounds and a setpoint plus one.
  localparam int CW = FREQ_BITS + 2;

  // Clamp a value to the bounds; the upper test wins when bounds are crossed.
  function automatic logic [FREQ_BITS-1:0] clamp(input logic [CW-1:0] v,
                                                 input logic [CW-1:0] ub,
                                                 input logic [CW-1:0] lb);
    logic [CW-1:0] r;
    begin
      if (v > ub) begin
        r = ub;
      end else if (v < lb) begin
        r = lb;
      end else begin
        r = v;
      end
      clamp = r[FREQ_BITS-1:0];
    end
  endfunction

  logic [CW-1:0] ub_w;
  logic [CW-1:0] lb_w;
  logic [CW-1:0] sp_w;
  logic [FREQ_BITS-1:0] ramped;

  assign ub_w = CW'(freq_ceil);
  assign lb_w = CW'(freq_floor);
  assign sp_w = CW'(setpoint);

  // One step toward the setpoint; never wraps since actual differs from it.
  assign ramped = (actual < setpoint) ? actual + FREQ_BITS'(1) : actual - FREQ_BITS'(1);

  always_comb begin
    mode_nxt     = mode;
    setpoint_nxt = setpoint;
    actual_nxt   = actual;
    smooth_nxt   = smooth;
    status_nxt   = status;
    flags        = '{changed: 1'b0, start: 1'b0, stop: 1'b0, led: LED_NONE};

    case (mode)
      // Configuring: exit key and setpoint stepping are independent.
      MODE_CONFIG: begin
        if (key_press == KEY_MENU) begin
          mode_nxt = MODE_NORMAL;
        end
        if (key_repeat == KEY_ONE) begin
          setpoint_nxt = clamp(sp_w + CW'(1), ub_w, lb_w);
        end else if (key_repeat == KEY_TWO) begin
          if (setpoint == '0) begin
            setpoint_nxt = clamp(lb_w, ub_w, lb_w);
          end else begin
            setpoint_nxt = clamp(sp_w - CW'(1), ub_w, lb_w);
          end
        end
      end

      // Updating: jump or ramp toward the setpoint, with raw stop abort.
      MODE_UPDATE: begin
        if (!smooth) begin
          actual_nxt    = setpoint;
          flags.changed = 1'b1;
          mode_nxt      = MODE_NORMAL;
        end else if (actual == setpoint) begin
          mode_nxt = MODE_NORMAL;
        end else if (key_raw == KEY_TWO) begin
          flags.stop    = 1'b1;
          actual_nxt    = '0;
          flags.changed = 1'b1;
          mode_nxt      = MODE_NORMAL;
        end else if (ramp_tick) begin
          actual_nxt    = ramped;
          flags.changed = 1'b1;
          if (ramped == setpoint) begin
            mode_nxt = MODE_NORMAL;
          end
        end
      end

      // Normal mode, and any code without meaning behaves the same way.
      default: begin
        mode_nxt = MODE_NORMAL;
        if (status_in != status) begin
          status_nxt = status_in;
          if (status_in == ST_STARTED) begin
            flags.led = LED_RED;
          end else if (status_in == ST_STOPPED) begin
            flags.led = LED_GREEN;
          end
        end
        case (key_press)
          KEY_ONE: begin
            flags.start = 1'b1;
            status_nxt  = ST_UPDATING;
            mode_nxt    = MODE_UPDATE;
            flags.led   = LED_BLUE;
          end
          KEY_TWO: begin
            flags.stop    = 1'b1;
            actual_nxt    = '0;
            flags.changed = 1'b1;
          end
          KEY_MENU: begin
            mode_nxt = MODE_CONFIG;
          end
          KEY_SMOOTH: begin
            smooth_nxt = ~smooth;
          end
          default: begin
          end
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/keypad_frequency_ramp_controller_core.sv =====
// Top level of the keypad frequency ramp controller core.
// Holds the state, configuration and result registers; uses kfrc_pkg and kfrc_step.
//
// Usage:
//   Each transfer on the in_ channel is one keypad scan (keys, motor status,
//   ramp tick). For each one the block returns exactly one result transfer on
//   the out_ channel with the mode, setpoint, actual frequency, command pulses,
//   LED color and remembered motor status after that scan.
//   The result is registered: it sits in the output register on the cycle
//   after the input transfer. Throughput is one scan per cycle while the
//   receiver takes each result; the step logic reads the state registers and
//   writes them back on the same edge that loads the output register.
//   When the receiver stalls, the held result stays stable and in_tready drops
//   until it is taken; in_tready is high whenever the output register is empty
//   or being emptied in the same cycle.
//   Reset (rst_n low, synchronous) empties the output register and puts the
//   controller in normal mode with setpoint 60, frequency 0, smoothing on,
//   status initial, upper bound 90 and lower bound 1.
//   The cfg_ port writes a bound with no wait and no read-back.
`default_nettype none

module keypad_frequency_ramp_controller_core #(
  parameter int FREQ_BITS = kfrc_pkg::FREQ_BITS_DEF,
  localparam int OUT_FIELDS_W = 2 * FREQ_BITS + 10,
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port.
  input  logic                               cfg_wr_en,
  input  logic                               cfg_index,
  input  logic [kfrc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata from bit 0: key_press[3], key_repeat[3], key_raw[3],
  // motor_status_in[2], ramp_tick[1], zero fill.
  input  logic [kfrc_pkg::IN_DATA_W-1:0]     in_tdata,
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata from bit 0: mode_out[2], setpoint_out[FREQ_BITS],
  // frequency_out[FREQ_BITS], frequency_changed, start_cmd, stop_cmd,
  // smooth_flag, led_color[2], motor_status_out[2], zero fill.
  output logic [OUT_DATA_W-1:0]              out_tdata
);
  import kfrc_pkg::*;

  localparam int PAD_W = OUT_DATA_W - OUT_FIELDS_W;

  // State and configuration registers.
  mode_t                   mode_r;
  logic [FREQ_BITS-1:0]    setpoint_r;
  logic [FREQ_BITS-1:0]    actual_r;
  logic                    smooth_r;
  logic [STATUS_BITS-1:0]  status_r;
  logic [CFG_DATA_W-1:0]   freq_ceil_r;
  logic [CFG_DATA_W-1:0]   freq_floor_r;

  // Output register.
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  // Step results.
  mode_t                   mode_nxt;
  logic [FREQ_BITS-1:0]    setpoint_nxt;
  logic [FREQ_BITS-1:0]    actual_nxt;
  logic                    smooth_nxt;
  logic [STATUS_BITS-1:0]  status_nxt;
  step_flags_t             flags;
  logic                    in_xfer;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  kfrc_step #(
    .FREQ_BITS (FREQ_BITS)
  ) u_step (
    .mode         (mode_r),
    .setpoint     (setpoint_r),
    .actual       (actual_r),
    .smooth       (smooth_r),
    .status       (status_r),
    .freq_ceil    (freq_ceil_r),
    .freq_floor   (freq_floor_r),
    .key_press    (in_tdata[2:0]),
    .key_repeat   (in_tdata[5:3]),
    .key_raw      (in_tdata[8:6]),
    .status_in    (in_tdata[10:9]),
    .ramp_tick    (in_tdata[11]),
    .mode_nxt     (mode_nxt),
    .setpoint_nxt (setpoint_nxt),
    .actual_nxt   (actual_nxt),
    .smooth_nxt   (smooth_nxt),
    .status_nxt   (status_nxt),
    .flags        (flags)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_ceil_r  <= FREQ_CEIL_RESET;
      freq_floor_r <= FREQ_FLOOR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_FREQ_CEIL:  freq_ceil_r  <= cfg_wdata;
        CFG_FREQ_FLOOR: freq_floor_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Controller state advances once per accepted scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      setpoint_r <= FREQ_BITS'(SETPOINT_RESET);
      actual_r   <= '0;
      smooth_r   <= 1'b1;
      status_r   <= ST_INITIAL;
    end else if (in_xfer) begin
      mode_r     <= mode_nxt;
      setpoint_r <= setpoint_nxt;
      actual_r   <= actual_nxt;
      smooth_r   <= smooth_nxt;
      status_r   <= status_nxt;
    end
  end

  // Result valid flag: set by an input transfer, cleared when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, packed from the lowest field up.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= {{PAD_W{1'b0}}, status_nxt, flags.led, smooth_nxt, flags.stop,
                     flags.start, flags.changed, actual_nxt, setpoint_nxt, mode_nxt};
    end
  end

endmodule

`default_nettype wire
